[hw/rtl/wads_pkg.sv]
// ----------------------------------------------------------------------------
// wads_pkg: shared types and constants of the wall align drive sequencer
// Codes for actions, drive commands, modes, phases and configuration
// registers, plus the configuration bundle and its reset values.
// ----------------------------------------------------------------------------
package wads_pkg;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_MOVE  = 2'd1,
		ACT_ALIGN = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		DRV_STOP = 2'd0,
		DRV_FWD  = 2'd1,
		DRV_CW   = 2'd2,
		DRV_CCW  = 2'd3
	} drive_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_MOVE  = 2'd1,
		MODE_ALIGN = 2'd2,
		MODE_DONE  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		PH_INIT   = 4'd0,
		PH_MEAS_L = 4'd1,
		PH_MEAS_R = 4'd2,
		PH_CHECK  = 4'd3,
		PH_TURN   = 4'd4,
		PH_CONF_L = 4'd5,
		PH_CONF_R = 4'd6,
		PH_APPR   = 4'd7,
		PH_APPR_L = 4'd8,
		PH_APPR_R = 4'd9,
		PH_DONE   = 4'd10
	} phase_t;

	typedef enum logic [2:0] {
		CFG_WALL_TOL     = 3'd0,
		CFG_CONFIRM_NEED = 3'd1,
		CFG_TARGET_WALL  = 3'd2,
		CFG_APPR_TOL     = 3'd3,
		CFG_TICKS_PER_CM = 3'd4,
		CFG_MEASURE_WAIT = 3'd5,
		CFG_TURN_TIME    = 3'd6,
		CFG_APPR_WAIT    = 3'd7
	} cfg_index_t;

	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_INDEX_W = 3;

	typedef struct packed {
		logic [7:0]  wall_tolerance_cm;
		logic [7:0]  confirm_needed;
		logic [8:0]  target_wall_cm;
		logic [7:0]  approach_tolerance_cm;
		logic [15:0] ticks_per_cm_q8;
		logic [7:0]  measure_wait_ms;
		logic [7:0]  turn_time_ms;
		logic [7:0]  approach_wait_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		wall_tolerance_cm:     8'd2,
		confirm_needed:        8'd3,
		target_wall_cm:        9'd10,
		approach_tolerance_cm: 8'd1,
		ticks_per_cm_q8:       16'd5120,
		measure_wait_ms:       8'd50,
		turn_time_ms:          8'd120,
		approach_wait_ms:      8'd10
	};

endpackage

[hw/rtl/wads_cfg_regs.sv]
// ----------------------------------------------------------------------------
// wads_cfg_regs: configuration register bank
// Eight write-only registers, loaded by index from the write port.
// ----------------------------------------------------------------------------
module wads_cfg_regs import wads_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_WALL_TOL:     cfg_q.wall_tolerance_cm     <= cfg_data[7:0];
				CFG_CONFIRM_NEED: cfg_q.confirm_needed        <= cfg_data[7:0];
				CFG_TARGET_WALL:  cfg_q.target_wall_cm        <= cfg_data[8:0];
				CFG_APPR_TOL:     cfg_q.approach_tolerance_cm <= cfg_data[7:0];
				CFG_TICKS_PER_CM: cfg_q.ticks_per_cm_q8       <= cfg_data[15:0];
				CFG_MEASURE_WAIT: cfg_q.measure_wait_ms       <= cfg_data[7:0];
				CFG_TURN_TIME:    cfg_q.turn_time_ms          <= cfg_data[7:0];
				CFG_APPR_WAIT:    cfg_q.approach_wait_ms      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/wads_core.sv]
// ----------------------------------------------------------------------------
// wads_core: sequencer state and next-state logic
// Applies one word per step to the mode, phase, timer, held readings,
// confirmation count, move target and drive command.
// ----------------------------------------------------------------------------
module wads_core import wads_pkg::*; #(
	parameter int unsigned MAX_VALID_CM  = 300,
	parameter int unsigned ENCODER_WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step_en,
	input  cfg_t                     cfg,
	input  logic [1:0]               action,
	input  logic [9:0]               distance_cm,
	input  logic [8:0]               left_cm,
	input  logic [8:0]               right_cm,
	input  logic [ENCODER_WIDTH-1:0] encoder_avg,
	output logic [1:0]               drive,
	output logic [1:0]               mode,
	output logic [3:0]               phase,
	output logic [8:0]               held_left,
	output logic [8:0]               held_right,
	output logic [7:0]               confirmations,
	output logic [ENCODER_WIDTH-1:0] move_target
);

	localparam int unsigned PROD_W = 26;
	localparam int unsigned TGT_W  = PROD_W - 8;
	localparam logic [8:0]  MAX_CM = 9'(MAX_VALID_CM);
	localparam logic [32:0] ENC_MAX = (33'd1 << ENCODER_WIDTH) - 33'd1;

	drive_t                   drive_q, drive_d;
	mode_t                    mode_q, mode_d;
	phase_t                   phase_q, phase_d;
	logic [7:0]               elapsed_q, elapsed_d, elapsed_inc;
	logic [8:0]               left_q, left_d;
	logic [8:0]               right_q, right_d;
	logic [7:0]               confirm_q, confirm_d, confirm_inc;
	logic [ENCODER_WIDTH-1:0] target_q, target_d;

	logic [PROD_W-1:0]        prod;
	logic [TGT_W-1:0]         prod_q8;
	logic [32:0]              prod_ext;
	logic [ENCODER_WIDTH-1:0] target_sat;

	logic       measure_ok, turn_ok, appr_ok;
	logic       held_bad;
	logic       held_aligned, conf_aligned;
	logic       appr_bad, appr_near;
	logic [8:0] held_diff, conf_diff;
	logic [9:0] appr_sum;
	logic [9:0] appr_limit;

	function automatic logic [8:0] abs_diff(input logic [8:0] a, input logic [8:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic bad_reading(input logic [8:0] v);
		return (v == 9'd0) || (v >= MAX_CM);
	endfunction

	// Move target: distance times Q8.8 ticks per cm, fraction dropped, saturated
	assign prod       = PROD_W'(distance_cm) * PROD_W'(cfg.ticks_per_cm_q8);
	assign prod_q8    = prod[PROD_W-1:8];
	assign prod_ext   = 33'(prod_q8);
	assign target_sat = (prod_ext > ENC_MAX) ? ENC_MAX[ENCODER_WIDTH-1:0]
	                                         : prod_ext[ENCODER_WIDTH-1:0];

	assign elapsed_inc = (elapsed_q == 8'hFF) ? elapsed_q : elapsed_q + 8'd1;
	assign confirm_inc = (confirm_q == 8'hFF) ? confirm_q : confirm_q + 8'd1;

	assign measure_ok = elapsed_inc >= cfg.measure_wait_ms;
	assign turn_ok    = elapsed_inc >= cfg.turn_time_ms;
	assign appr_ok    = elapsed_inc >= cfg.approach_wait_ms;

	assign held_diff    = abs_diff(left_q, right_q);
	assign held_bad     = bad_reading(left_q) || bad_reading(right_q);
	assign held_aligned = held_diff <= {1'b0, cfg.wall_tolerance_cm};

	// Right reading is taken on this tick; compare against it directly
	assign conf_diff    = abs_diff(left_q, right_cm);
	assign conf_aligned = conf_diff <= {1'b0, cfg.wall_tolerance_cm};
	assign appr_bad     = bad_reading(left_q) || bad_reading(right_cm);
	assign appr_sum     = {1'b0, left_q} + {1'b0, right_cm};
	assign appr_limit   = {1'b0, cfg.target_wall_cm} + {2'b00, cfg.approach_tolerance_cm};
	assign appr_near    = {1'b0, appr_sum[9:1]} <= appr_limit;

	always_comb begin
		drive_d   = drive_q;
		mode_d    = mode_q;
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		left_d    = left_q;
		right_d   = right_q;
		confirm_d = confirm_q;
		target_d  = target_q;
		if (step_en) begin
			unique case (action_t'(action))
				ACT_MOVE: begin
					target_d = target_sat;
					drive_d  = DRV_FWD;
					mode_d   = MODE_MOVE;
				end
				ACT_ALIGN: begin
					mode_d    = MODE_ALIGN;
					phase_d   = PH_INIT;
					elapsed_d = 8'd0;
					confirm_d = 8'd0;
				end
				ACT_TICK: begin
					elapsed_d = elapsed_inc;
					if (mode_q == MODE_MOVE) begin
						if (encoder_avg >= target_q) begin
							drive_d = DRV_STOP;
							mode_d  = MODE_DONE;
						end
					end else if (mode_q == MODE_ALIGN) begin
						unique case (phase_q)
							PH_INIT: begin
								phase_d   = PH_MEAS_L;
								elapsed_d = 8'd0;
							end
							PH_MEAS_L: begin
								if (measure_ok) begin
									left_d    = left_cm;
									elapsed_d = 8'd0;
									phase_d   = PH_MEAS_R;
								end
							end
							PH_MEAS_R: begin
								if (measure_ok) begin
									right_d   = right_cm;
									elapsed_d = 8'd0;
									phase_d   = PH_CHECK;
								end
							end
							PH_CHECK: begin
								elapsed_d = 8'd0;
								if (held_bad) begin
									drive_d = DRV_STOP;
									phase_d = PH_MEAS_L;
								end else if (held_aligned) begin
									drive_d   = DRV_STOP;
									confirm_d = 8'd0;
									phase_d   = PH_CONF_L;
								end else begin
									drive_d = (left_q > right_q) ? DRV_CW : DRV_CCW;
									phase_d = PH_TURN;
								end
							end
							PH_TURN: begin
								if (turn_ok) begin
									drive_d   = DRV_STOP;
									phase_d   = PH_MEAS_L;
									elapsed_d = 8'd0;
								end
							end
							PH_CONF_L: begin
								if (measure_ok) begin
									left_d    = left_cm;
									elapsed_d = 8'd0;
									phase_d   = PH_CONF_R;
								end
							end
							PH_CONF_R: begin
								if (measure_ok) begin
									right_d   = right_cm;
									elapsed_d = 8'd0;
									if (conf_aligned) begin
										confirm_d = confirm_inc;
										if (confirm_inc >= cfg.confirm_needed) begin
											drive_d = DRV_STOP;
											phase_d = PH_APPR;
										end else begin
											phase_d = PH_CONF_L;
										end
									end else begin
										confirm_d = 8'd0;
										phase_d   = PH_MEAS_L;
									end
								end
							end
							PH_APPR: begin
								drive_d   = DRV_FWD;
								phase_d   = PH_APPR_L;
								elapsed_d = 8'd0;
							end
							PH_APPR_L: begin
								if (appr_ok) begin
									left_d    = left_cm;
									elapsed_d = 8'd0;
									phase_d   = PH_APPR_R;
								end
							end
							PH_APPR_R: begin
								if (appr_ok) begin
									right_d   = right_cm;
									elapsed_d = 8'd0;
									if (appr_bad || appr_near) begin
										drive_d = DRV_STOP;
										phase_d = PH_DONE;
									end else begin
										phase_d = PH_APPR_L;
									end
								end
							end
							PH_DONE: mode_d = MODE_DONE;
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q   <= DRV_STOP;
			mode_q    <= MODE_IDLE;
			phase_q   <= PH_INIT;
			elapsed_q <= 8'd0;
			left_q    <= 9'd0;
			right_q   <= 9'd0;
			confirm_q <= 8'd0;
			target_q  <= '0;
		end else begin
			drive_q   <= drive_d;
			mode_q    <= mode_d;
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			left_q    <= left_d;
			right_q   <= right_d;
			confirm_q <= confirm_d;
			target_q  <= target_d;
		end
	end

	assign drive         = drive_q;
	assign mode          = mode_q;
	assign phase         = phase_q;
	assign held_left     = left_q;
	assign held_right    = right_q;
	assign confirmations = confirm_q;
	assign move_target   = target_q;

endmodule

[hw/rtl/wall_align_drive_sequencer.sv]
// ----------------------------------------------------------------------------
// wall_align_drive_sequencer: distance move and wall alignment sequencer
// Takes tick and start-command words; drives a move or a wall alignment.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid / item_stall): one word per 1 ms tick or start
//   command. Action 0 is a tick with left/right distances and encoder count,
//   1 starts a distance move, 2 starts wall alignment, 3 is ignored.
//   Result channel (result_valid / result_stall): one word per item, the
//   drive command and sequencer state after that item.
//   Config port: cfg_wr_en writes cfg_data into register cfg_index; write only
//   while no word is in flight.
//   Path: an accepted word goes through the input register, then the state
//   registers, which also serve as the result register.
//   Throughput: one word per unstalled cycle; next state is combinational.
//   Reset: mode idle, phase init, drive stop, all holds and counters zero,
//   config registers at their defaults; both channels empty.
//   Stall: a stalled result holds the state; one more word waits in the
//   input register, after which item_stall rises.
// ----------------------------------------------------------------------------
module wall_align_drive_sequencer import wads_pkg::*; #(
	parameter int unsigned MAX_VALID_CM  = 300,
	parameter int unsigned ENCODER_WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write port
	input  logic                     cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	// item channel
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [1:0]               action,
	input  logic [9:0]               distance_cm,
	input  logic [8:0]               left_cm,
	input  logic [8:0]               right_cm,
	input  logic [ENCODER_WIDTH-1:0] encoder_avg,
	// result channel
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [1:0]               drive,
	output logic [1:0]               mode,
	output logic [3:0]               phase,
	output logic [8:0]               held_left,
	output logic [8:0]               held_right,
	output logic [7:0]               confirmations,
	output logic [ENCODER_WIDTH-1:0] move_target
);

	cfg_t cfg;

	logic                     valid_s1;
	logic [1:0]               action_s1;
	logic [9:0]               distance_s1;
	logic [8:0]               left_s1;
	logic [8:0]               right_s1;
	logic [ENCODER_WIDTH-1:0] encoder_s1;

	logic result_valid_q;
	logic advance;
	logic load_s1;

	wads_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance the buffered word into the state when the result slot is free
	// or is being taken this cycle.
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign load_s1    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	// Payload holds no reset; load only on acceptance
	always_ff @(posedge clk) begin
		if (load_s1) begin
			action_s1   <= action;
			distance_s1 <= distance_cm;
			left_s1     <= left_cm;
			right_s1    <= right_cm;
			encoder_s1  <= encoder_avg;
		end
	end

	// Result valid: set on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	wads_core #(
		.MAX_VALID_CM  (MAX_VALID_CM),
		.ENCODER_WIDTH (ENCODER_WIDTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (advance),
		.cfg           (cfg),
		.action        (action_s1),
		.distance_cm   (distance_s1),
		.left_cm       (left_s1),
		.right_cm      (right_s1),
		.encoder_avg   (encoder_s1),
		.drive         (drive),
		.mode          (mode),
		.phase         (phase),
		.held_left     (held_left),
		.held_right    (held_right),
		.confirmations (confirmations),
		.move_target   (move_target)
	);

	assign result_valid = result_valid_q;

endmodule
